[hw/rtl/sfmt_pkg.sv]
package sfmt_pkg;

  localparam int GENERATORS = 4;
  localparam int WORDS      = 624;
  localparam int BLOCKS     = WORDS / 4;
  localparam int REC_POS    = 122;
  localparam int ADDR_W     = $clog2(GENERATORS * WORDS);
  localparam int GEN_W      = (GENERATORS > 1) ? $clog2(GENERATORS) : 1;
  localparam int POS_W      = 10;
  localparam int BLK_W      = 8;

  localparam logic [31:0]  INIT_MULT  = 32'd1812433253;
  localparam logic [63:0]  CHAIN_XOR  = 64'd1337;
  localparam logic [31:0]  PARITY_W0  = 32'h00000001;
  localparam logic [31:0]  PARITY_W3  = 32'h13c9e684;
  localparam logic [127:0] REC_MASK   =
    {32'hbffffff6, 32'hbffaffff, 32'hddfecb7f, 32'hdfffffef};

  typedef enum logic {OP_SEED = 1'b0, OP_DRAW = 1'b1} sfmt_op_t;

  typedef struct packed {
    logic        opcode;
    logic [63:0] frame_seed;
    logic [1:0]  generator_index;
  } sfmt_in_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic [22:0] unit_fraction;
  } sfmt_out_t;

  // one step of the block recursion, 128-bit little-endian words
  function automatic logic [127:0] block_step(input logic [127:0] a, input logic [127:0] b,
                                              input logic [127:0] c, input logic [127:0] d);
    logic [127:0] y;
    logic [127:0] v;
    for (int k = 0; k < 4; k++) begin
      y[k*32 +: 32] = (b[k*32 +: 32] >> 11) & REC_MASK[k*32 +: 32];
      v[k*32 +: 32] = d[k*32 +: 32] << 18;
    end
    return a ^ (a << 8) ^ (c >> 8) ^ y ^ v;
  endfunction

endpackage

[hw/rtl/sfmt_front.sv]
module sfmt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sfmt_pkg::sfmt_in_t in_data,
  output logic              q_valid,
  output sfmt_pkg::sfmt_in_t q_data,
  input  logic              q_pop
);

  sfmt_pkg::sfmt_in_t ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       keep;

  // draws from a generator that does not exist are dropped here
  assign keep = (in_data.opcode == sfmt_pkg::OP_SEED) ||
                (32'(in_data.generator_index) < sfmt_pkg::GENERATORS);
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wp_r] <= in_data;
        wp_r        <= ~wp_r;
      end
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[hw/rtl/sfmt_engine.sv]
module sfmt_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sfmt_pkg::sfmt_in_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sfmt_pkg::sfmt_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEED, S_CERT, S_FETCH, S_WRITE, S_DREQ, S_DOUT
  } state_t;

  localparam int AW = sfmt_pkg::ADDR_W;
  localparam int GW = sfmt_pkg::GEN_W;
  localparam int PW = sfmt_pkg::POS_W;
  localparam int BW = sfmt_pkg::BLK_W;

  state_t          state_r;
  logic [GW-1:0]   gen_r;
  logic [63:0]     chain_r;
  logic [PW-1:0]   w_r;
  logic [31:0]     p_r;
  logic [31:0]     w0_r;
  logic [31:0]     w3_r;
  logic [BW-1:0]   blk_r;
  logic [3:0]      cnt_r;
  logic            pre_r;
  logic [31:0]     buf_r [8];
  logic [127:0]    r1_r;
  logic [127:0]    r2_r;
  logic [PW-1:0]   pos_r [sfmt_pkg::GENERATORS];
  sfmt_pkg::sfmt_out_t out_r;
  logic            out_valid_r;

  logic [31:0]     mem [sfmt_pkg::GENERATORS * sfmt_pkg::WORDS];
  logic [31:0]     rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [31:0]     wr_data;
  logic            wr_en;

  logic [AW-1:0]   base;
  logic [PW-1:0]   word_a;
  logic [PW-1:0]   word_b;
  logic [BW-1:0]   blk_j;
  logic [31:0]     seed_word;
  logic [31:0]     p_mix;
  logic [127:0]    blk_new;
  logic            out_free;
  logic            par_odd;

  assign base      = AW'(gen_r * sfmt_pkg::WORDS);
  assign blk_j     = (blk_r < BW'(sfmt_pkg::BLOCKS - sfmt_pkg::REC_POS)) ?
                     blk_r + BW'(sfmt_pkg::REC_POS) :
                     blk_r - BW'(sfmt_pkg::BLOCKS - sfmt_pkg::REC_POS);
  assign word_a    = {blk_r, 2'b00} + PW'(cnt_r[1:0]);
  assign word_b    = {blk_j, 2'b00} + PW'(cnt_r[1:0]);
  assign p_mix     = p_r ^ (p_r >> 30);
  assign seed_word = (w_r == '0) ? chain_r[31:0] :
                     32'(sfmt_pkg::INIT_MULT * p_mix) + 32'(w_r);
  assign blk_new   = sfmt_pkg::block_step({buf_r[3], buf_r[2], buf_r[1], buf_r[0]},
                                          {buf_r[7], buf_r[6], buf_r[5], buf_r[4]},
                                          r1_r, r2_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign par_odd   = ^((w0_r & sfmt_pkg::PARITY_W0) ^ (w3_r & sfmt_pkg::PARITY_W3));
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = base + AW'(w_r);
    wr_data = seed_word;
    rd_addr = base + AW'(pos_r[gen_r]);
    unique case (state_r)
      S_SEED: wr_en = 1'b1;
      S_CERT: begin
        wr_en   = !par_odd;
        wr_addr = base;
        wr_data = w0_r ^ 32'h1;
      end
      S_FETCH: begin
        if (pre_r) rd_addr = base + AW'(sfmt_pkg::WORDS - 8) + AW'(cnt_r[2:0]);
        else if (!cnt_r[2]) rd_addr = base + AW'(word_a);
        else rd_addr = base + AW'(word_b);
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = base + AW'(word_a);
        wr_data = blk_new[cnt_r[1:0]*32 +: 32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= '0;
      cnt_r       <= '0;
      pre_r       <= 1'b0;
      for (int g = 0; g < sfmt_pkg::GENERATORS; g++) pos_r[g] <= PW'(sfmt_pkg::WORDS);
    end else begin
      // the output state sets valid itself
      if (out_valid_r && !out_stall && state_r != S_DOUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.opcode == sfmt_pkg::OP_SEED) begin
              chain_r <= q_data.frame_seed;
              gen_r   <= '0;
              w_r     <= '0;
              state_r <= S_SEED;
            end else begin
              gen_r <= GW'(q_data.generator_index);
              if (pos_r[GW'(q_data.generator_index)] >= PW'(sfmt_pkg::WORDS)) begin
                blk_r   <= '0;
                cnt_r   <= '0;
                pre_r   <= 1'b1;
                state_r <= S_FETCH;
              end else begin
                state_r <= S_DREQ;
              end
            end
          end
        end
        S_SEED: begin
          p_r <= seed_word;
          if (w_r == PW'(0)) w0_r <= seed_word;
          if (w_r == PW'(3)) w3_r <= seed_word;
          if (w_r == PW'(sfmt_pkg::WORDS - 1)) state_r <= S_CERT;
          else w_r <= w_r + PW'(1);
        end
        S_CERT: begin
          pos_r[gen_r] <= PW'(sfmt_pkg::WORDS);
          chain_r      <= chain_r ^ (chain_r << 1) ^ sfmt_pkg::CHAIN_XOR;
          w_r          <= '0;
          if (32'(gen_r) == sfmt_pkg::GENERATORS - 1) begin
            state_r <= S_IDLE;
          end else begin
            gen_r   <= gen_r + GW'(1);
            state_r <= S_SEED;
          end
        end
        S_FETCH: begin
          if (cnt_r != 4'd0) buf_r[3'(cnt_r - 4'd1)] <= rd_data_r;
          if (cnt_r == 4'd8) begin
            cnt_r <= '0;
            if (pre_r) begin
              // last two blocks seed the recursion
              pre_r <= 1'b0;
              r1_r  <= {buf_r[3], buf_r[2], buf_r[1], buf_r[0]};
              r2_r  <= {rd_data_r, buf_r[6], buf_r[5], buf_r[4]};
            end else begin
              state_r <= S_WRITE;
            end
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_WRITE: begin
          if (cnt_r == 4'd3) begin
            r1_r  <= r2_r;
            r2_r  <= blk_new;
            cnt_r <= '0;
            if (blk_r == BW'(sfmt_pkg::BLOCKS - 1)) begin
              pos_r[gen_r] <= '0;
              state_r      <= S_DREQ;
            end else begin
              blk_r   <= blk_r + BW'(1);
              state_r <= S_FETCH;
            end
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_DREQ: state_r <= S_DOUT;
        S_DOUT: begin
          if (out_free) begin
            out_r.random_word   <= rd_data_r;
            out_r.unit_fraction <= rd_data_r[31:9];
            out_valid_r         <= 1'b1;
            pos_r[gen_r]        <= pos_r[gen_r] + PW'(1);
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/sfmt19937_generator_core.sv]
// channel | direction | handshake                    | payload
// in      | input     | in_valid / in_stall          | opcode, frame_seed, generator_index
// out     | output    | out_valid / out_stall        | random_word, unit_fraction
// a draw in the engine when words remain steps through pop, memory read and output
// an exhausted generator first loads its last two blocks, then rebuilds all 156 blocks
// in turn through the state memory's single read port and single write port
// seeding writes one word per cycle
// reset marks every generator exhausted; memory contents stay undefined until seeded
// a two-entry command queue keeps taking items while the engine or the output stalls, until full
module sfmt19937_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfmt_pkg::sfmt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfmt_pkg::sfmt_out_t out_data
);

  logic               q_valid;
  logic               q_pop;
  sfmt_pkg::sfmt_in_t q_data;

  sfmt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  sfmt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
